>>> design/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication form of the above.
`define ASSERT_IMPL(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

>>> design/mcpa_pkg.sv
// Types and constants for the multi-contour polygon area block.
package mcpa_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int PROD_WIDTH  = 2 * COORD_WIDTH;
    localparam int SUM_WIDTH   = 64;
    localparam int AREA_WIDTH  = 63;

    localparam logic [AREA_WIDTH-1:0] AREA_MAX = '1;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x_coord;
        logic signed [COORD_WIDTH-1:0] y_coord;
        logic                          is_hole;
        logic                          contour_end;
        logic                          polygon_end;
    } vertex_t;

    typedef struct packed {
        logic [AREA_WIDTH-1:0] contour_area;
        logic [AREA_WIDTH-1:0] total_area;
        logic                  last;
    } area_t;

    // Control that travels with a vertex down the pipeline.
    typedef struct packed {
        logic valid;
        logic mid;          // contour already open when this vertex arrived
        logic closing;      // contour end or polygon end
        logic is_hole;
        logic polygon_end;
    } stage_ctl_t;

endpackage

>>> design/multi_contour_polygon_area.sv
// Shoelace area of polygons with holes, one vertex accepted per cycle unless
// stalled, six register stages from vertex to result: input, products, term
// differences, cross-sum accumulate, magnitude, total. A vertex transfer can
// happen every cycle; a contour end's result is presented from the total
// stage, other vertices yield none. Empty stages fill up while the result
// port is stalled, so the vertex side stalls only once every stage holds an
// item.
// Areas are |cross sum| read with 2*F+1 fraction bits (Q.25 for Q11.12 input).
module multi_contour_polygon_area (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              vertex_valid,
    output logic              vertex_stall,
    input  mcpa_pkg::vertex_t vertex,
    output logic              area_valid,
    input  logic              area_stall,
    output mcpa_pkg::area_t   area
);
    import mcpa_pkg::*;

    logic en1, en2, en3, en4, en5, en6;
    logic accept;
    logic closing_in;

    // contour state
    logic signed [COORD_WIDTH-1:0] first_x_reg, first_y_reg;
    logic signed [COORD_WIDTH-1:0] prev_x_reg, prev_y_reg;
    logic                          mid_contour_reg;
    logic signed [SUM_WIDTH-1:0]   cross_sum_reg;
    logic [AREA_WIDTH-1:0]         total_reg;

    // stage 1
    stage_ctl_t                    ctl1_reg;
    logic signed [COORD_WIDTH-1:0] x1_reg, y1_reg;
    logic signed [COORD_WIDTH-1:0] px1_reg, py1_reg, fx1_reg, fy1_reg;

    // stage 2
    stage_ctl_t                    ctl2;
    logic signed [PROD_WIDTH-1:0]  prod_a, prod_b, prod_c, prod_d;
    logic signed [PROD_WIDTH:0]    edge_diff, close_diff;

    // stage 3
    stage_ctl_t                    ctl3_reg;
    logic signed [SUM_WIDTH-1:0]   term1_reg, term2_reg;
    logic signed [SUM_WIDTH-1:0]   cross_sum_next;

    // stage 4
    logic                          v4_reg, hole4_reg, pend4_reg;
    logic [SUM_WIDTH-1:0]          sum4_reg;
    logic [SUM_WIDTH-1:0]          sum_abs;
    logic [AREA_WIDTH-1:0]         area_mag;

    // stage 5
    logic                          v5_reg, pend5_reg;
    logic [AREA_WIDTH-1:0]         area5_reg;
    logic [SUM_WIDTH-1:0]          total_sum;
    logic [AREA_WIDTH-1:0]         total_next;

    // output stage
    logic                          out_valid_reg;
    area_t                         out_reg;

    // a stage takes a new item when it is empty or its item moves on
    assign en6 = !out_valid_reg || !area_stall;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign en3 = !ctl3_reg.valid || en4;
    assign en2 = !ctl2.valid || en3;
    assign en1 = !ctl1_reg.valid || en2;

    assign vertex_stall = !en1;
    assign accept       = vertex_valid && en1;
    assign closing_in   = vertex.contour_end || vertex.polygon_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_x_reg     <= '0;
            first_y_reg     <= '0;
            prev_x_reg      <= '0;
            prev_y_reg      <= '0;
            mid_contour_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (!mid_contour_reg)
            begin
                first_x_reg <= vertex.x_coord;
                first_y_reg <= vertex.y_coord;
            end
            prev_x_reg      <= vertex.x_coord;
            prev_y_reg      <= vertex.y_coord;
            mid_contour_reg <= !closing_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
        end
        else if (en1)
        begin
            ctl1_reg.valid       <= vertex_valid;
            ctl1_reg.mid         <= mid_contour_reg;
            ctl1_reg.closing     <= closing_in;
            ctl1_reg.is_hole     <= vertex.is_hole;
            ctl1_reg.polygon_end <= vertex.polygon_end;
        end
    end

    // on a contour's first vertex the first point is the vertex itself
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            x1_reg  <= vertex.x_coord;
            y1_reg  <= vertex.y_coord;
            px1_reg <= prev_x_reg;
            py1_reg <= prev_y_reg;
            fx1_reg <= mid_contour_reg ? first_x_reg : vertex.x_coord;
            fy1_reg <= mid_contour_reg ? first_y_reg : vertex.y_coord;
        end
    end

    mcpa_products u_products (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en2),
        .ctl_in  (ctl1_reg),
        .x_coord (x1_reg),
        .y_coord (y1_reg),
        .prev_x  (px1_reg),
        .prev_y  (py1_reg),
        .first_x (fx1_reg),
        .first_y (fy1_reg),
        .ctl_out (ctl2),
        .prod_a  (prod_a),
        .prod_b  (prod_b),
        .prod_c  (prod_c),
        .prod_d  (prod_d)
    );

    assign edge_diff  = {prod_a[PROD_WIDTH-1], prod_a} - {prod_b[PROD_WIDTH-1], prod_b};
    assign close_diff = {prod_c[PROD_WIDTH-1], prod_c} - {prod_d[PROD_WIDTH-1], prod_d};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl3_reg <= '0;
        end
        else if (en3)
        begin
            ctl3_reg <= ctl2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            term1_reg <= ctl2.mid
                ? {{(SUM_WIDTH-PROD_WIDTH-1){edge_diff[PROD_WIDTH]}}, edge_diff}
                : '0;
            term2_reg <= ctl2.closing
                ? {{(SUM_WIDTH-PROD_WIDTH-1){close_diff[PROD_WIDTH]}}, close_diff}
                : '0;
        end
    end

    // accumulator restarts on a contour's first vertex, wraps mod 2^64
    assign cross_sum_next = (ctl3_reg.mid ? cross_sum_reg : '0) + term1_reg + term2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cross_sum_reg <= '0;
            v4_reg        <= 1'b0;
        end
        else if (en4)
        begin
            v4_reg <= ctl3_reg.valid && ctl3_reg.closing;
            if (ctl3_reg.valid)
            begin
                cross_sum_reg <= cross_sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            sum4_reg  <= cross_sum_next;
            hole4_reg <= ctl3_reg.is_hole;
            pend4_reg <= ctl3_reg.polygon_end;
        end
    end

    // |sum|; only -2^63 has no 63-bit magnitude
    assign sum_abs  = sum4_reg[SUM_WIDTH-1] ? (~sum4_reg + 1'b1) : sum4_reg;
    assign area_mag = sum_abs[SUM_WIDTH-1] ? AREA_MAX : sum_abs[AREA_WIDTH-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else if (en5)
        begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            area5_reg <= hole4_reg ? '0 : area_mag;
            pend5_reg <= pend4_reg;
        end
    end

    assign total_sum  = {1'b0, total_reg} + {1'b0, area5_reg};
    assign total_next = total_sum[SUM_WIDTH-1] ? AREA_MAX : total_sum[AREA_WIDTH-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
        end
        else if (en6)
        begin
            out_valid_reg <= v5_reg;
            if (v5_reg)
            begin
                total_reg <= pend5_reg ? '0 : total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en6 && v5_reg)
        begin
            out_reg.contour_area <= area5_reg;
            out_reg.total_area   <= total_next;
            out_reg.last         <= pend5_reg;
        end
    end

    assign area_valid = out_valid_reg;
    assign area       = out_reg;

endmodule

>>> design/mcpa_products.sv
// Multiplier stage: the four shoelace partial products, registered.
module mcpa_products (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        en,
    input  mcpa_pkg::stage_ctl_t                        ctl_in,
    input  logic signed [mcpa_pkg::COORD_WIDTH-1:0]     x_coord,
    input  logic signed [mcpa_pkg::COORD_WIDTH-1:0]     y_coord,
    input  logic signed [mcpa_pkg::COORD_WIDTH-1:0]     prev_x,
    input  logic signed [mcpa_pkg::COORD_WIDTH-1:0]     prev_y,
    input  logic signed [mcpa_pkg::COORD_WIDTH-1:0]     first_x,
    input  logic signed [mcpa_pkg::COORD_WIDTH-1:0]     first_y,
    output mcpa_pkg::stage_ctl_t                        ctl_out,
    output logic signed [mcpa_pkg::PROD_WIDTH-1:0]      prod_a,
    output logic signed [mcpa_pkg::PROD_WIDTH-1:0]      prod_b,
    output logic signed [mcpa_pkg::PROD_WIDTH-1:0]      prod_c,
    output logic signed [mcpa_pkg::PROD_WIDTH-1:0]      prod_d
);
    import mcpa_pkg::*;

    stage_ctl_t                   ctl_reg;
    logic signed [PROD_WIDTH-1:0] prod_a_reg;
    logic signed [PROD_WIDTH-1:0] prod_b_reg;
    logic signed [PROD_WIDTH-1:0] prod_c_reg;
    logic signed [PROD_WIDTH-1:0] prod_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    // edge term prev_x*y - x*prev_y, closing term x*first_y - first_x*y
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_a_reg <= prev_x * y_coord;
            prod_b_reg <= x_coord * prev_y;
            prod_c_reg <= x_coord * first_y;
            prod_d_reg <= first_x * y_coord;
        end
    end

    assign ctl_out = ctl_reg;
    assign prod_a  = prod_a_reg;
    assign prod_b  = prod_b_reg;
    assign prod_c  = prod_c_reg;
    assign prod_d  = prod_d_reg;

endmodule

>>> design/mcpa_checker.sv
// Port-level checks for the polygon area block, bound to the top level.
`include "assert_macros.svh"

module mcpa_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              vertex_valid,
    input logic              vertex_stall,
    input logic              area_valid,
    input logic              area_stall,
    input mcpa_pkg::area_t   area
);

    `ASSERT_CLK(a_result_held, area_valid && area_stall |=> area_valid, "result dropped while stalled")
    `ASSERT_CLK(a_payload_held, area_valid && area_stall |=> $stable(area), "stalled result changed")
    `ASSERT_IMPL(a_total_covers_contour, area_valid, area.total_area >= area.contour_area, "total below contour area")
    `ASSERT_IMPL(a_no_stall_when_drained, !area_stall, !vertex_stall, "vertex stalled with result side free")

endmodule

bind multi_contour_polygon_area mcpa_checker u_mcpa_checker (.*);
